// ===== rtl/sru_pkg.sv =====
// ----------------------------------------------------------------------------
// sru_pkg
// Shared types, operation and width codes, and width helpers for the x86
// shift and rotate unit.
// ----------------------------------------------------------------------------
package sru_pkg;

  localparam logic [3:0] OP_SHL  = 4'd0;
  localparam logic [3:0] OP_SHR  = 4'd1;
  localparam logic [3:0] OP_SAR  = 4'd2;
  localparam logic [3:0] OP_ROL  = 4'd3;
  localparam logic [3:0] OP_ROR  = 4'd4;
  localparam logic [3:0] OP_RCL  = 4'd5;
  localparam logic [3:0] OP_RCR  = 4'd6;
  localparam logic [3:0] OP_SHLD = 4'd7;
  localparam logic [3:0] OP_SHRD = 4'd8;

  localparam logic [1:0] W_8  = 2'd0;
  localparam logic [1:0] W_16 = 2'd1;
  localparam logic [1:0] W_32 = 2'd2;
  localparam logic [1:0] W_64 = 2'd3;

  localparam int FLAG_CF = 0;
  localparam int FLAG_PF = 1;
  localparam int FLAG_AF = 2;
  localparam int FLAG_ZF = 3;
  localparam int FLAG_SF = 4;
  localparam int FLAG_OF = 5;

  // Registered request
  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  wcode;
    logic [63:0] dest;
    logic [63:0] src;
    logic [7:0]  cnt;
    logic [5:0]  flags;
  } req_t;

  // Count decode
  typedef struct packed {
    logic       nop;    // masked count zero or undefined operation
    logic       clamp;  // shl count beyond the operand width
    logic [5:0] n;      // effective count
    logic [6:0] amt;    // right-shift amount into the funnel
  } cnt_t;

  // Shifter output
  typedef struct packed {
    logic [63:0] value;
    logic        cf;
  } core_t;

  // Result
  typedef struct packed {
    logic [63:0] value;
    logic        wb;
    logic [5:0]  flags;
  } rsp_t;

  function automatic logic [63:0] operand_mask(input logic [1:0] wcode);
    logic [63:0] m;
    unique case (wcode)
      W_8:  m = 64'h0000_0000_0000_00FF;
      W_16: m = 64'h0000_0000_0000_FFFF;
      W_32: m = 64'h0000_0000_FFFF_FFFF;
      W_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [6:0] width_bits(input logic [1:0] wcode);
    logic [6:0] b;
    unique case (wcode)
      W_8:  b = 7'd8;
      W_16: b = 7'd16;
      W_32: b = 7'd32;
      W_64: b = 7'd64;
    endcase
    return b;
  endfunction

  function automatic logic top_bit(input logic [63:0] v, input logic [1:0] wcode);
    logic b;
    unique case (wcode)
      W_8:  b = v[7];
      W_16: b = v[15];
      W_32: b = v[31];
      W_64: b = v[63];
    endcase
    return b;
  endfunction

  function automatic logic next_bit(input logic [63:0] v, input logic [1:0] wcode);
    logic b;
    unique case (wcode)
      W_8:  b = v[6];
      W_16: b = v[14];
      W_32: b = v[30];
      W_64: b = v[62];
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/sru_count_decode.sv =====
// ----------------------------------------------------------------------------
// sru_count_decode
// Count masking per operation and width, and the funnel shift amount.
// ----------------------------------------------------------------------------
module sru_count_decode (
  input  sru_pkg::req_t req,
  output sru_pkg::cnt_t cnt
);

  localparam logic [4:0] MOD9_X3 = 5'd27;
  localparam logic [4:0] MOD9_X2 = 5'd18;
  localparam logic [4:0] MOD9_X1 = 5'd9;
  localparam logic [4:0] MOD17   = 5'd17;

  logic [6:0] bits;
  logic [5:0] cm;
  logic [5:0] rot;
  logic [5:0] rc;
  logic [4:0] c5;
  logic [4:0] rc8;
  logic [4:0] rc16;

  always_comb begin
    bits = sru_pkg::width_bits(req.wcode);
    c5   = req.cnt[4:0];
    cm   = (req.wcode == sru_pkg::W_64) ? req.cnt[5:0] : {1'b0, c5};

    unique case (req.wcode)
      sru_pkg::W_8:  rot = {3'd0, req.cnt[2:0]};
      sru_pkg::W_16: rot = {2'd0, req.cnt[3:0]};
      sru_pkg::W_32: rot = {1'b0, req.cnt[4:0]};
      sru_pkg::W_64: rot = req.cnt[5:0];
    endcase

    // modulo 9 and 17 of a 5-bit count
    rc8 = (c5 >= MOD9_X3) ? c5 - MOD9_X3 :
          (c5 >= MOD9_X2) ? c5 - MOD9_X2 :
          (c5 >= MOD9_X1) ? c5 - MOD9_X1 : c5;
    rc16 = (c5 >= MOD17) ? c5 - MOD17 : c5;

    unique case (req.wcode)
      sru_pkg::W_8:  rc = {1'b0, rc8};
      sru_pkg::W_16: rc = {1'b0, rc16};
      sru_pkg::W_32: rc = cm;
      sru_pkg::W_64: rc = cm;
    endcase

    cnt.clamp = 1'b0;
    unique case (req.op) inside
      sru_pkg::OP_SHR, sru_pkg::OP_SAR: begin
        cnt.n   = cm;
        cnt.amt = {1'b0, cm};
      end
      sru_pkg::OP_SHL: begin
        cnt.n     = cm;
        cnt.clamp = {1'b0, cm} > bits;
        cnt.amt   = cnt.clamp ? 7'd0 : bits - {1'b0, cm};
      end
      sru_pkg::OP_ROR, sru_pkg::OP_SHRD: begin
        cnt.n   = rot;
        cnt.amt = {1'b0, rot};
      end
      sru_pkg::OP_ROL, sru_pkg::OP_SHLD: begin
        cnt.n   = rot;
        cnt.amt = bits - {1'b0, rot};
      end
      sru_pkg::OP_RCR: begin
        cnt.n   = rc;
        cnt.amt = {1'b0, rc};
      end
      sru_pkg::OP_RCL: begin
        cnt.n   = rc;
        // left rotate through carry as a right rotate over width+1 bits
        cnt.amt = bits + 7'd1 - {1'b0, rc};
      end
      default: begin
        cnt.n   = 6'd0;
        cnt.amt = 7'd0;
      end
    endcase

    cnt.nop = (cnt.n == 6'd0);
  end

endmodule

// ===== rtl/sru_shift_core.sv =====
// ----------------------------------------------------------------------------
// sru_shift_core
// One funnel right shifter serves every operation. Left forms shift right
// by the complement of the count; a guard bit below the funnel catches the
// last bit shifted out on the right.
// ----------------------------------------------------------------------------
module sru_shift_core (
  input  sru_pkg::req_t  req,
  input  sru_pkg::cnt_t  cnt,
  output sru_pkg::core_t core
);

  // hi placed directly above a field of operand width
  function automatic logic [129:0] join_w(input logic [129:0] hi, input logic [129:0] lo,
                                          input logic [1:0] wcode);
    logic [129:0] r;
    unique case (wcode)
      sru_pkg::W_8:  r = (hi << 8) | lo;
      sru_pkg::W_16: r = (hi << 16) | lo;
      sru_pkg::W_32: r = (hi << 32) | lo;
      sru_pkg::W_64: r = (hi << 64) | lo;
    endcase
    return r;
  endfunction

  // same, above a field of width+1 (rotate through carry)
  function automatic logic [129:0] join_w1(input logic [129:0] hi, input logic [129:0] lo,
                                           input logic [1:0] wcode);
    logic [129:0] r;
    unique case (wcode)
      sru_pkg::W_8:  r = (hi << 9) | lo;
      sru_pkg::W_16: r = (hi << 17) | lo;
      sru_pkg::W_32: r = (hi << 33) | lo;
      sru_pkg::W_64: r = (hi << 65) | lo;
    endcase
    return r;
  endfunction

  logic [63:0]  mask;
  logic [63:0]  val;
  logic [63:0]  src;
  logic [63:0]  val_ext;
  logic         fill;
  logic [129:0] z;
  logic [129:0] payload;
  logic [130:0] rout;
  logic         hi_cf;

  always_comb begin
    mask    = sru_pkg::operand_mask(req.wcode);
    val     = req.dest & mask;
    src     = req.src & mask;
    fill    = (req.op == sru_pkg::OP_SAR) && sru_pkg::top_bit(val, req.wcode);
    val_ext = fill ? (val | ~mask) : val;
    z       = join_w(130'(req.flags[sru_pkg::FLAG_CF]), 130'(val), req.wcode);

    case (req.op) inside
      sru_pkg::OP_SHR, sru_pkg::OP_SAR: payload = {{66{fill}}, val_ext};
      sru_pkg::OP_SHL:                  payload = join_w(130'(val), 130'd0, req.wcode);
      sru_pkg::OP_ROL, sru_pkg::OP_ROR: payload = join_w(130'(val), 130'(val), req.wcode);
      sru_pkg::OP_RCL, sru_pkg::OP_RCR: payload = join_w1(z, z, req.wcode);
      sru_pkg::OP_SHLD:                 payload = join_w(130'(val), 130'(src), req.wcode);
      sru_pkg::OP_SHRD:                 payload = join_w(130'(src), 130'(val), req.wcode);
      default:                          payload = 130'(val);
    endcase

    rout = {payload, 1'b0} >> cnt.amt;

    // bit just above the operand field: last bit out for left forms
    unique case (req.wcode)
      sru_pkg::W_8:  hi_cf = rout[9];
      sru_pkg::W_16: hi_cf = rout[17];
      sru_pkg::W_32: hi_cf = rout[33];
      sru_pkg::W_64: hi_cf = rout[65];
    endcase

    core.value = cnt.clamp ? 64'd0 : (rout[64:1] & mask);

    case (req.op) inside
      sru_pkg::OP_SHR, sru_pkg::OP_SAR, sru_pkg::OP_SHRD: core.cf = rout[0];
      sru_pkg::OP_SHL:                                    core.cf = hi_cf & ~cnt.clamp;
      sru_pkg::OP_SHLD, sru_pkg::OP_RCL, sru_pkg::OP_RCR: core.cf = hi_cf;
      sru_pkg::OP_ROL:                                    core.cf = core.value[0];
      sru_pkg::OP_ROR: core.cf = sru_pkg::top_bit(core.value, req.wcode);
      default:                                            core.cf = 1'b0;
    endcase
  end

endmodule

// ===== rtl/sru_flag_gen.sv =====
// ----------------------------------------------------------------------------
// sru_flag_gen
// Flag update per operation and the final select for a zero count.
// ----------------------------------------------------------------------------
module sru_flag_gen (
  input  sru_pkg::req_t  req,
  input  sru_pkg::cnt_t  cnt,
  input  sru_pkg::core_t core,
  output sru_pkg::rsp_t  rsp
);

  logic [63:0] val;
  logic [63:0] res;
  logic        rmsb;
  logic        rnext;
  logic        omsb;
  logic        onext;
  logic        old_cf;
  logic        one;
  logic [5:0]  fl;

  always_comb begin
    val    = req.dest & sru_pkg::operand_mask(req.wcode);
    res    = core.value;
    rmsb   = sru_pkg::top_bit(res, req.wcode);
    rnext  = sru_pkg::next_bit(res, req.wcode);
    omsb   = sru_pkg::top_bit(val, req.wcode);
    onext  = sru_pkg::next_bit(val, req.wcode);
    old_cf = req.flags[sru_pkg::FLAG_CF];
    one    = (cnt.n == 6'd1);
    fl     = req.flags;

    case (req.op) inside
      sru_pkg::OP_SHL, sru_pkg::OP_SHR, sru_pkg::OP_SAR,
      sru_pkg::OP_SHLD, sru_pkg::OP_SHRD: begin
        fl[sru_pkg::FLAG_CF] = core.cf;
        fl[sru_pkg::FLAG_AF] = 1'b0;
        fl[sru_pkg::FLAG_ZF] = (res == 64'd0);
        fl[sru_pkg::FLAG_SF] = rmsb;
        fl[sru_pkg::FLAG_PF] = ~^res[7:0];
        if (req.op == sru_pkg::OP_SHL) begin
          fl[sru_pkg::FLAG_OF] = omsb ^ onext;
        end else if (req.op == sru_pkg::OP_SHR) begin
          fl[sru_pkg::FLAG_OF] = omsb;
        end else if (req.op == sru_pkg::OP_SHLD) begin
          fl[sru_pkg::FLAG_OF] = one & (rmsb ^ core.cf);
        end else if (req.op == sru_pkg::OP_SHRD) begin
          fl[sru_pkg::FLAG_OF] = one & (omsb ^ rmsb);
        end else begin
          fl[sru_pkg::FLAG_OF] = 1'b0;
        end
      end
      sru_pkg::OP_ROL: begin
        fl[sru_pkg::FLAG_CF] = core.cf;
        if (one) begin
          fl[sru_pkg::FLAG_OF] = rmsb ^ core.cf;
        end
      end
      sru_pkg::OP_ROR: begin
        fl[sru_pkg::FLAG_CF] = core.cf;
        if (one) begin
          fl[sru_pkg::FLAG_OF] = rmsb ^ rnext;
        end
      end
      sru_pkg::OP_RCL: begin
        fl[sru_pkg::FLAG_CF] = core.cf;
        fl[sru_pkg::FLAG_OF] = omsb ^ onext;
      end
      sru_pkg::OP_RCR: begin
        fl[sru_pkg::FLAG_CF] = core.cf;
        fl[sru_pkg::FLAG_OF] = omsb ^ old_cf;
      end
      default: ;
    endcase

    rsp.wb    = ~cnt.nop;
    rsp.value = cnt.nop ? val : res;
    rsp.flags = cnt.nop ? req.flags : fl;
  end

endmodule

// ===== rtl/x86_shift_rotate_unit.sv =====
// ----------------------------------------------------------------------------
// x86_shift_rotate_unit
// x86 shift and rotate execution unit: SHL/SAL, SHR, SAR, ROL, ROR, RCL,
// RCR, SHLD, SHRD at 8, 16, 32 or 64 bits with flag update.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid / in_stall with req_type, width_code,
//   dest_value, source_value, shift_count and flags_in. A request is taken
//   at a clock edge with in_valid high and in_stall low.
//   Result channel: out_valid / out_stall with shifted_value, write_back and
//   flags_out; taken at an edge with out_valid high and out_stall low.
//   A taken request moves from the request register to the result register,
//   where it is offered. Throughput: one request per cycle unless stalled.
//   The request register feeds the count decode, a single 131-bit funnel
//   right shifter and the flag logic, which land in the result register;
//   that one combinational pass sets the cycle.
//   A stalled result holds in the result register; the request register
//   still accepts one more request, and in_stall rises only when both
//   registers are full and out_stall is high.
//   Reset (rst, synchronous) empties both registers; no clearing pass.
//   A masked count of zero or an undefined operation returns the operand
//   and flags unchanged with write_back low.
// ----------------------------------------------------------------------------
module x86_shift_rotate_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  req_type,
  input  logic [1:0]  width_code,
  input  logic [63:0] dest_value,
  input  logic [63:0] source_value,
  input  logic [7:0]  shift_count,
  input  logic [5:0]  flags_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] shifted_value,
  output logic        write_back,
  output logic [5:0]  flags_out
);

  sru_pkg::req_t  req;
  logic           req_valid;
  sru_pkg::cnt_t  cnt;
  sru_pkg::core_t core;
  sru_pkg::rsp_t  rsp_next;
  sru_pkg::rsp_t  rsp;
  logic           rsp_ready;

  assign rsp_ready = ~out_valid | ~out_stall;
  assign in_stall  = req_valid & ~rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        req_valid <= in_valid;
      end
      if (rsp_ready) begin
        out_valid <= req_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req <= '{op: req_type, wcode: width_code, dest: dest_value, src: source_value,
               cnt: shift_count, flags: flags_in};
    end
    if (req_valid && rsp_ready) begin
      rsp <= rsp_next;
    end
  end

  sru_count_decode u_decode (
    .req (req),
    .cnt (cnt)
  );

  sru_shift_core u_core (
    .req  (req),
    .cnt  (cnt),
    .core (core)
  );

  sru_flag_gen u_flags (
    .req  (req),
    .cnt  (cnt),
    .core (core),
    .rsp  (rsp_next)
  );

  assign shifted_value = rsp.value;
  assign write_back    = rsp.wb;
  assign flags_out     = rsp.flags;

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (req_valid && out_valid && out_stall))
    else $error("in_stall without a full pipeline");

  a_move_forward: assert property (@(posedge clk) disable iff (rst)
    (req_valid && rsp_ready) |=> out_valid)
    else $error("request lost between request and result registers");

  a_hold_request: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !rsp_ready) |=> (req_valid && $stable(req)))
    else $error("blocked request register changed");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !req_valid) |=> !out_valid)
    else $error("result repeated after it was taken");

endmodule
